// ----- hw/rtl/ttd_pkg.sv -----
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared constants for the turn-then-drive point controller: default sizes,
// register map, drive mode codes and the arctangent table of the CORDIC unit.
// ----------------------------------------------------------------------------
package ttd_pkg;

  localparam int POS_WIDTH_DEF     = 32;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int ATAN_LEN = 24;

  // atan(2^-i) / pi * 2^31, half-turns in Q1.31
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // reciprocal of the CORDIC gain, Q0.32
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_DIST_THRESH  = 2'd0;
  localparam logic [1:0] REG_ANGLE_THRESH = 2'd1;
  localparam logic [1:0] REG_STEP_RATE    = 2'd2;

  localparam logic [31:0] DIST_THRESH_RST  = 32'd655;
  localparam logic [14:0] ANGLE_THRESH_RST = 15'd328;
  localparam logic [31:0] STEP_RATE_RST    = 32'd65536;

  // drive modes
  localparam logic [1:0] MODE_ALIGN = 2'd0;
  localparam logic [1:0] MODE_TURN  = 2'd1;
  localparam logic [1:0] MODE_DRIVE = 2'd2;

endpackage

// ----- hw/rtl/ttd_cordic.sv -----
// ----------------------------------------------------------------------------
// ttd_cordic
// Pipelined vectoring CORDIC, one micro-rotation per register stage, with a
// sideband word carried alongside each request.
// ----------------------------------------------------------------------------
module ttd_cordic #(
  parameter int XW     = 36,
  parameter int STAGES = 16,
  parameter int SW     = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ce,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic [31:0]          in_z,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [XW-1:0] out_x,
  output logic [31:0]          out_z,
  output logic [SW-1:0]        out_side
);

  logic                 vld  [STAGES+1];
  logic signed [XW-1:0] xs   [STAGES+1];
  logic signed [XW-1:0] ys   [STAGES+1];
  logic [31:0]          zs   [STAGES+1];
  logic [SW-1:0]        side [STAGES+1];

  assign vld[0]  = in_valid;
  assign xs[0]   = in_x;
  assign ys[0]   = in_y;
  assign zs[0]   = in_z;
  assign side[0] = in_side;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XW-1:0] x_sh;
    logic signed [XW-1:0] y_sh;

    assign x_sh = xs[i] >>> i;
    assign y_sh = ys[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (ce) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        side[i+1] <= side[i];
        // rotate toward the x axis
        if (!ys[i][XW-1]) begin
          xs[i+1] <= xs[i] + y_sh;
          ys[i+1] <= ys[i] - x_sh;
          zs[i+1] <= zs[i] + ttd_pkg::ATAN_TAB[i];
        end else begin
          xs[i+1] <= xs[i] - y_sh;
          ys[i+1] <= ys[i] + x_sh;
          zs[i+1] <= zs[i] - ttd_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign out_x     = xs[STAGES];
  assign out_z     = zs[STAGES];
  assign out_side  = side[STAGES];

  // final y is only a residue
  logic unused_y;
  assign unused_y = ^ys[STAGES];

endmodule

// ----- hw/rtl/turn_then_drive_controller.sv -----
// ----------------------------------------------------------------------------
// turn_then_drive_controller
// Point controller for a differential-drive robot: turn first, then drive.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one request per pose pair (current and target pose).
//   m_* stream: one drive command per request, in order; m_tuser carries the
//   drive mode, m_tdata the forward speed and turn rate.
//   APB port: distance threshold, angle threshold and step rate at 0x0, 0x4,
//   0x8; write only while no request is in flight.
// Pipeline:
//   one stage of position difference, one half-turn pre-rotation stage, one
//   per CORDIC micro-rotation, two for the gain correction multiply, one
//   decision stage, one rate multiply and one saturation/output stage.
//   throughput is one request per cycle while the output is not stalled;
//   every stage is a register stage.
// Reset:
//   rst clears all valid bits and loads the register defaults.
// Stall:
//   while m_tvalid is high and m_tready low the whole pipeline holds and
//   s_tready is low; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module turn_then_drive_controller #(
  parameter int POS_WIDTH     = ttd_pkg::POS_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = ttd_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = ttd_pkg::CORDIC_STAGES_DEF,
  localparam int IN_W = ((4*POS_WIDTH + 2*ANGLE_WIDTH + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  // current_x, current_y, current_heading, target_x, target_y, target_heading
  input  logic [IN_W-1:0] s_tdata,
  output logic            m_tvalid,
  input  logic            m_tready,
  // forward_speed, turn_rate
  output logic [63:0]     m_tdata,
  // drive_mode
  output logic [1:0]      m_tuser,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int P   = POS_WIDTH;
  localparam int A   = ANGLE_WIDTH;
  localparam int XW  = P + 4;
  localparam int XHW = (XW > 32) ? XW - 32 : 1;
  localparam int MW  = XHW + 32;
  localparam int CW  = (A > 15) ? A : 15;
  localparam int PW  = A + 33;
  localparam logic [31:0] ZROUND = 32'd1 << (31 - A);

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  logic [31:0] dist_thresh;
  logic [14:0] angle_thresh;
  logic [31:0] step_rate;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_thresh  <= ttd_pkg::DIST_THRESH_RST;
      angle_thresh <= ttd_pkg::ANGLE_THRESH_RST;
      step_rate    <= ttd_pkg::STEP_RATE_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        ttd_pkg::REG_DIST_THRESH:  dist_thresh  <= pwdata;
        ttd_pkg::REG_ANGLE_THRESH: angle_thresh <= pwdata[14:0];
        ttd_pkg::REG_STEP_RATE:    step_rate    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ttd_pkg::REG_DIST_THRESH:  prdata = dist_thresh;
      ttd_pkg::REG_ANGLE_THRESH: prdata = {17'd0, angle_thresh};
      ttd_pkg::REG_STEP_RATE:    prdata = step_rate;
      default:                   prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline enable
  // --------------------------------------------------------------------------
  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  logic signed [P-1:0] cx, cy, tx, ty;
  logic [A-1:0]        ch, th;

  assign cx = s_tdata[P-1:0];
  assign cy = s_tdata[2*P-1:P];
  assign ch = s_tdata[2*P+A-1:2*P];
  assign tx = s_tdata[3*P+A-1:2*P+A];
  assign ty = s_tdata[4*P+A-1:3*P+A];
  assign th = s_tdata[4*P+2*A-1:4*P+A];

  // stage 0: position difference
  logic                v0;
  logic signed [P:0]   dx0, dy0;
  logic [A-1:0]        ch0, th0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (ce) v0 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dx0 <= {tx[P-1], tx} - {cx[P-1], cx};
      dy0 <= {ty[P-1], ty} - {cy[P-1], cy};
      ch0 <= ch;
      th0 <= th;
    end
  end

  // stage 1: half-turn pre-rotation into the right half plane
  logic                v1;
  logic signed [XW-1:0] x1, y1;
  logic [31:0]         z1;
  logic [2*A-1:0]      side1;
  logic signed [XW-1:0] dx0e, dy0e;

  assign dx0e = XW'(dx0);
  assign dy0e = XW'(dy0);

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (ce) v1 <= v0;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side1 <= {th0, ch0};
      if (dx0[P]) begin
        x1 <= -dx0e;
        y1 <= -dy0e;
        z1 <= 32'h80000000;
      end else begin
        x1 <= dx0e;
        y1 <= dy0e;
        z1 <= 32'd0;
      end
    end
  end

  // CORDIC
  logic                 vc;
  logic signed [XW-1:0] xc;
  logic [31:0]          zc;
  logic [2*A-1:0]       sidec;

  ttd_cordic #(
    .XW     (XW),
    .STAGES (CORDIC_STAGES),
    .SW     (2*A)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (v1),
    .in_x      (x1),
    .in_y      (y1),
    .in_z      (z1),
    .in_side   (side1),
    .out_valid (vc),
    .out_x     (xc),
    .out_z     (zc),
    .out_side  (sidec)
  );

  // stage m1: gain correction products, bearing error
  logic [MW-1:0]  xe;
  logic [31:0]    zsum;
  logic [A-1:0]   bearing;
  logic [A-1:0]   chc, thc;

  assign xe      = MW'($unsigned(xc));
  assign zsum    = zc + ZROUND;
  assign bearing = zsum[31:32-A];
  assign chc     = sidec[A-1:0];
  assign thc     = sidec[2*A-1:A];

  logic           vm1;
  logic [63:0]    plo;
  logic [MW-1:0]  phi;
  logic [A-1:0]   err1, herr1;

  always_ff @(posedge clk) begin
    if (rst) vm1 <= 1'b0;
    else if (ce) vm1 <= vc;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      plo   <= 64'(xe[31:0]) * 64'(ttd_pkg::INV_GAIN);
      phi   <= MW'(xe[MW-1:32]) * MW'(ttd_pkg::INV_GAIN);
      err1  <= bearing - chc;
      herr1 <= thc - chc;
    end
  end

  // stage m2: rounded magnitude, absolute bearing error
  logic [64:0]   plo_rnd;
  logic          vm2;
  logic [MW-1:0] mag2;
  logic [A-1:0]  err2, herr2, aerr2;

  assign plo_rnd = {1'b0, plo} + 65'h80000000;

  always_ff @(posedge clk) begin
    if (rst) vm2 <= 1'b0;
    else if (ce) vm2 <= vm1;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      mag2  <= phi + MW'(plo_rnd[64:32]);
      err2  <= err1;
      herr2 <= herr1;
      // most negative error maps to 2^(A-1) as unsigned
      aerr2 <= err1[A-1] ? -err1 : err1;
    end
  end

  // stage d: mode decision
  logic          vd;
  logic [1:0]    mode_d;
  logic [A-1:0]  ang_d;
  logic [MW-1:0] mag_d;

  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else if (ce) vd <= vm2;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      priority if (mag2 <= MW'(dist_thresh)) begin
        mode_d <= ttd_pkg::MODE_ALIGN;
        ang_d  <= herr2;
        mag_d  <= '0;
      end else if (CW'(aerr2) > CW'(angle_thresh)) begin
        mode_d <= ttd_pkg::MODE_TURN;
        ang_d  <= err2;
        mag_d  <= '0;
      end else begin
        mode_d <= ttd_pkg::MODE_DRIVE;
        ang_d  <= '0;
        mag_d  <= mag2;
      end
    end
  end

  // stage r1: rate products
  logic               vr;
  logic [1:0]         mode_r;
  logic signed [PW-1:0] prod_a;
  logic [63:0]        p1;
  logic [MW-1:0]      p2;

  always_ff @(posedge clk) begin
    if (rst) vr <= 1'b0;
    else if (ce) vr <= vd;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      mode_r <= mode_d;
      prod_a <= PW'(signed'(ang_d)) * signed'(PW'({1'b0, step_rate}));
      p1     <= 64'(mag_d[31:0]) * 64'(step_rate);
      p2     <= MW'(mag_d[MW-1:32]) * MW'(step_rate);
    end
  end

  // stage r2: scaling and saturation into the output register
  logic signed [PW-1:0] rate_sh;
  logic [PW-32:0]       rate_hi;
  logic [31:0]          rate_sat;
  logic [48:0]          spd_sum;
  logic [31:0]          spd_sat;

  assign rate_sh = prod_a >>> (A - 1);
  assign rate_hi = rate_sh[PW-1:31];
  assign spd_sum = {17'd0, p2[15:0], 16'd0} + {1'b0, p1[63:16]};

  always_comb begin
    if ((&rate_hi) || !(|rate_hi)) rate_sat = rate_sh[31:0];
    else if (rate_sh[PW-1])        rate_sat = 32'h80000000;
    else                           rate_sat = 32'h7FFFFFFF;

    if ((|p2[MW-1:16]) || (|spd_sum[48:32])) spd_sat = 32'hFFFFFFFF;
    else                                     spd_sat = spd_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (ce) m_tvalid <= vr;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tuser <= mode_r;
      m_tdata <= {rate_sat, spd_sat};
    end
  end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// turn-then-drive controller testbench
// Sends pose pairs over the input stream, predicts each drive command with a
// behavioral CORDIC and decision model, and compares mode, speed and turn rate
// of every command in order. Registers are written over APB between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int LATENCY = ttd_pkg::CORDIC_STAGES_DEF + 7;
  localparam int LIMIT   = 400000;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic signed [15:0] th;
    logic signed [31:0] ty;
    logic signed [31:0] tx;
    logic signed [15:0] ch;
    logic signed [31:0] cy;
    logic signed [31:0] cx;
  } pose_pair_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] speed;
    logic [31:0] rate;
  } drive_cmd_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [159:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  turn_then_drive_controller u_top (.*);

  initial forever #5 clk = ~clk;

  // predictor copy of the registers
  logic [31:0] dist_thresh = ttd_pkg::DIST_THRESH_RST;
  logic [14:0] angle_thresh = ttd_pkg::ANGLE_THRESH_RST;
  logic [31:0] step_rate = ttd_pkg::STEP_RATE_RST;

  drive_cmd_t expected_cmds[$];
  int  errors = 0;
  int  cycles = 0;
  bit  idle_on = 1;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] rate_of(longint signed a);
    longint signed r;
    r = (a * longint'(step_rate)) >>> 15;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic longint signed wrap16(longint signed a);
    logic signed [15:0] w;
    w = a[15:0];
    return longint'(w);
  endfunction

  function automatic drive_cmd_t predict_command(pose_pair_t p);
    drive_cmd_t c;
    longint signed x, y, xs, ys, err, aerr;
    logic [31:0] z;
    logic [63:0] xu, mag, bearing, p1, p2, r;
    x = longint'(p.tx) - longint'(p.cx);
    y = longint'(p.ty) - longint'(p.cy);
    z = 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < ttd_pkg::CORDIC_STAGES_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ttd_pkg::ATAN_TAB[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ttd_pkg::ATAN_TAB[i];
      end
    end
    xu = x;
    mag = (xu >> 32) * 64'(ttd_pkg::INV_GAIN)
          + (((xu & 64'hFFFFFFFF) * 64'(ttd_pkg::INV_GAIN) + 64'h80000000) >> 32);
    bearing = (64'(z) + 64'h8000) >> 16;
    c.speed = 0;
    c.rate = 0;
    if (mag <= 64'(dist_thresh)) begin
      c.mode = ttd_pkg::MODE_ALIGN;
      c.rate = rate_of(wrap16(longint'(p.th) - longint'(p.ch)));
    end else begin
      err = wrap16(longint'(bearing) - longint'(p.ch));
      aerr = err < 0 ? -err : err;
      if (aerr > longint'(angle_thresh)) begin
        c.mode = ttd_pkg::MODE_TURN;
        c.rate = rate_of(err);
      end else begin
        c.mode = ttd_pkg::MODE_DRIVE;
        p2 = (mag >> 32) * 64'(step_rate);
        p1 = (mag & 64'hFFFFFFFF) * 64'(step_rate);
        if (p2 >= 64'h10000) c.speed = 32'hFFFFFFFF;
        else begin
          r = (p2 << 16) + (p1 >> 16);
          c.speed = r > 64'hFFFFFFFF ? 32'hFFFFFFFF : r[31:0];
        end
      end
    end
    return c;
  endfunction

  // output side: random stall bursts and command checking
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (expected_cmds.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected command mode=%0d", m_tuser);
        end else begin
          drive_cmd_t e;
          e = expected_cmds.pop_front();
          if (m_tuser !== e.mode || m_tdata[31:0] !== e.speed
              || m_tdata[63:32] !== e.rate) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp mode=%0d spd=%h rate=%h got mode=%0d spd=%h rate=%h",
                       e.mode, e.speed, e.rate, m_tuser, m_tdata[31:0], m_tdata[63:32]);
          end
        end
      end
      if (idle_on && m_tready && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 8);
        m_tready <= 0;
        repeat (gap) @(posedge clk);
        // accepts at the last stall edge cannot happen since m_tready was low
      end
      m_tready <= 1;
    end
  end

  task automatic send_request(pose_pair_t p);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tdata <= p;
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    expected_cmds.push_back(predict_command(p));
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      ttd_pkg::REG_DIST_THRESH:  dist_thresh = val;
      ttd_pkg::REG_ANGLE_THRESH: angle_thresh = val[14:0];
      ttd_pkg::REG_STEP_RATE:    step_rate = val;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 400000)) - 200000;
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $signed($urandom_range(0, 20000000)) - 10000000;
    endcase
  endfunction

  function automatic pose_pair_t rand_pose();
    pose_pair_t p;
    p.cx = rand_pos(); p.cy = rand_pos();
    p.tx = rand_pos(); p.ty = rand_pos();
    p.ch = 16'($urandom()); p.th = 16'($urandom());
    // small offsets give arrival and near-aligned cases
    if ($urandom_range(0, 3) == 0) begin
      p.tx = p.cx + ($signed($urandom_range(0, 2000)) - 1000);
      p.ty = p.cy + ($signed($urandom_range(0, 2000)) - 1000);
    end
    return p;
  endfunction

  task automatic test_directed();
    pose_pair_t p;
    longint signed vals[6] = '{0, 1, -1, 32'sh7FFFFFFF, -32'sh80000000, 65536};
    p = '0;
    send_request(p);                  // zero distance
    p.th = 16'h7FFF; send_request(p);
    p.th = 16'h8000; p.ch = 16'h0000; send_request(p);
    foreach (vals[i]) begin
      p = '0;
      p.cx = 32'(vals[i]); p.tx = 32'(vals[5 - i]); p.cy = 32'(vals[(i + 2) % 6]);
      p.ty = 32'(vals[(i + 3) % 6]);
      p.ch = 16'h8000 + 16'(i); p.th = 16'h7FFF - 16'(i);
      send_request(p);
    end
    // straight drive along +x, and along -x with heading of a half-turn
    p = '0; p.tx = 32'sd10 << 16; send_request(p);
    p = '0; p.tx = -(32'sd10 << 16); p.ch = 16'h8000; send_request(p);
    p = '0; p.ty = 32'sd10 << 16; p.ch = 16'h4000; send_request(p);
    p = '0; p.ty = -(32'sd10 << 16); p.ch = 16'h4000; send_request(p);
    p = '0; p.cx = 32'h80000000; p.tx = 32'h7FFFFFFF; send_request(p);
    p = '0; p.cy = 32'h80000000; p.ty = 32'h7FFFFFFF; p.ch = 16'h4000; send_request(p);
    drain();
  endtask

  task automatic test_random(int count);
    repeat (count) send_request(rand_pose());
    drain();
  endtask

  task automatic test_settings();
    write_reg(ttd_pkg::REG_DIST_THRESH, 32'd0);
    write_reg(ttd_pkg::REG_ANGLE_THRESH, 32'hFFFF_FFFF);
    write_reg(ttd_pkg::REG_STEP_RATE, 32'hFFFFFFFF);
    test_random(200);
    write_reg(ttd_pkg::REG_DIST_THRESH, 32'hFFFFFFFF);
    write_reg(ttd_pkg::REG_ANGLE_THRESH, 32'd0);
    write_reg(ttd_pkg::REG_STEP_RATE, 32'd0);
    test_random(150);
    write_reg(ttd_pkg::REG_DIST_THRESH, $urandom_range(0, 100000));
    write_reg(ttd_pkg::REG_ANGLE_THRESH, 32'd4000);
    write_reg(ttd_pkg::REG_STEP_RATE, 32'd1);
    test_random(200);
    write_reg(ttd_pkg::REG_DIST_THRESH, 32'd655);
    write_reg(ttd_pkg::REG_ANGLE_THRESH, 32'h7FFF);
    write_reg(ttd_pkg::REG_STEP_RATE, 32'h0100_0000);
    test_random(200);
    write_reg(REG_UNMAPPED, 32'h1234);  // unmapped index, ignored
    write_reg(ttd_pkg::REG_ANGLE_THRESH, 32'd328);
    write_reg(ttd_pkg::REG_STEP_RATE, 32'd65536);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_settings();
    idle_on = 0;
    test_random(280);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ttd_pkg.sv
hw/rtl/ttd_cordic.sv
hw/rtl/turn_then_drive_controller.sv
test/tb.sv
